// ----- src/sli_pkg.sv -----
package sli_pkg;

    // operation codes on the op field
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // status codes on the status field
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // width of the count fields of a result
    localparam int OUT_CNT_W = 5;

    // width of one stored value
    localparam int VALUE_W = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_HEAD,
        ST_REM_SCAN,
        ST_DONE
    } state_t;

endpackage

// ----- src/sli_ram.sv -----
module sli_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/sorted_list_insert_remove.sv -----
// Sorted table of signed 32-bit values with insert and remove-all.
//
// Input channel (in_valid / in_stall, fields op and value): a transaction is
// taken when in_valid is high and in_stall low. op insert places value after
// all equal entries; op remove deletes every entry equal to value.
// Output channel (out_valid / out_stall, fields status, removed_count,
// occupancy): exactly one result transaction per input transaction, in order.
//
// The table lives in one RAM with registered read. An insert walks down from
// the last entry, shifting larger entries up one place per cycle; a remove
// walks up from the first entry, compacting survivors. Reads are issued one
// per cycle, each in the cycle before its write-back. An insert runs longer
// the more entries lie above value, and a remove the higher the occupancy;
// a full-table insert or an operation on an empty table goes straight to the
// result. in_stall is high while an operation is in flight and drops as the
// result is loaded, so the next transaction is taken in the next cycle, even
// while that result still waits in the output register; if the receiver
// stalls and a second result is ready, the sequencer holds it.
// Reset empties the table (occupancy zero) and drops any pending result.
module sorted_list_insert_remove
    import sli_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic signed [VALUE_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        status,
    output logic [OUT_CNT_W-1:0]        removed_count,
    output logic [OUT_CNT_W-1:0]        occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic [AW-1:0]              scan_idx_reg, scan_idx_next;
    logic                       issue_reg, issue_next;
    logic                       pend_reg, pend_next;
    logic [AW-1:0]              pend_idx_reg, pend_idx_next;
    logic [CW-1:0]              wr_ptr_reg, wr_ptr_next;
    logic                       res_status_reg, res_status_next;
    logic [CW-1:0]              res_removed_reg, res_removed_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       status_reg, status_next;
    logic [OUT_CNT_W-1:0]       removed_count_reg, removed_count_next;
    logic [OUT_CNT_W-1:0]       occupancy_reg, occupancy_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_wr_addr;
    logic [VALUE_W-1:0]         ram_wr_data;
    logic [VALUE_W-1:0]         ram_rd_data;

    logic [CW-1:0]              last_cnt;
    logic [AW-1:0]              last_idx;
    logic [AW-1:0]              pend_up;
    logic                       rd_greater;
    logic                       rd_keep;
    logic [CW-1:0]              wr_inc;
    logic [CW+OUT_CNT_W-1:0]    occ_ext;
    logic [CW+OUT_CNT_W-1:0]    rem_ext;

    sli_ram
    #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    )
    u_ram
    (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rd_data)
    );

    // helpers on the counters and the returning read data
    assign last_cnt   = count_reg - 1'b1;
    assign last_idx   = last_cnt[AW-1:0];
    assign pend_up    = pend_idx_reg + 1'b1;
    assign rd_greater = $signed(ram_rd_data) > value_reg;
    assign rd_keep    = ram_rd_data != value_reg;
    assign wr_inc     = wr_ptr_reg + {{(CW-1){1'b0}}, rd_keep};
    assign occ_ext    = {{OUT_CNT_W{1'b0}}, count_reg};
    assign rem_ext    = {{OUT_CNT_W{1'b0}}, res_removed_reg};

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_count = removed_count_reg;
    assign occupancy     = occupancy_reg;

    // sequencer: next state, ram write port, result loading
    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        value_next         = value_reg;
        scan_idx_next      = scan_idx_reg;
        issue_next         = issue_reg;
        pend_next          = pend_reg;
        pend_idx_next      = pend_idx_reg;
        wr_ptr_next        = wr_ptr_reg;
        res_status_next    = res_status_reg;
        res_removed_next   = res_removed_reg;
        out_valid_next     = out_valid_reg && out_stall;
        status_next        = status_reg;
        removed_count_next = removed_count_reg;
        occupancy_next     = occupancy_reg;
        ram_we             = 1'b0;
        ram_wr_addr        = '0;
        ram_wr_data        = value_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next       = value;
                    res_status_next  = STATUS_DONE;
                    res_removed_next = '0;
                    issue_next       = 1'b1;
                    pend_next        = 1'b0;
                    wr_ptr_next      = '0;
                    if (op == OP_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            ram_we      = 1'b1;
                            ram_wr_addr = '0;
                            ram_wr_data = value;
                            count_next  = count_reg + 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            scan_idx_next = last_idx;
                            state_next    = ST_INS_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            scan_idx_next = '0;
                            state_next    = ST_REM_SCAN;
                        end
                    end
                end
            end

            // walk down from the last entry, shifting larger ones up
            ST_INS_SCAN:
            begin
                pend_next = issue_reg;
                if (issue_reg)
                begin
                    pend_idx_next = scan_idx_reg;
                    if (scan_idx_reg == '0)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg - 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = pend_up;
                    if (rd_greater)
                    begin
                        ram_wr_data = ram_rd_data;
                        if (pend_idx_reg == '0)
                        begin
                            state_next = ST_INS_HEAD;
                        end
                    end
                    else
                    begin
                        ram_wr_data = value_reg;
                        count_next  = count_reg + 1'b1;
                        state_next  = ST_DONE;
                    end
                end
            end

            // every entry was larger: new value goes to the front
            ST_INS_HEAD:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = value_reg;
                count_next  = count_reg + 1'b1;
                state_next  = ST_DONE;
            end

            // walk up from the first entry, compacting survivors
            ST_REM_SCAN:
            begin
                pend_next = issue_reg;
                if (issue_reg)
                begin
                    pend_idx_next = scan_idx_reg;
                    if (scan_idx_reg == last_idx)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    ram_we      = rd_keep;
                    ram_wr_addr = wr_ptr_reg[AW-1:0];
                    ram_wr_data = ram_rd_data;
                    wr_ptr_next = wr_inc;
                    if (pend_idx_reg == last_idx)
                    begin
                        count_next       = wr_inc;
                        res_removed_next = count_reg - wr_inc;
                        state_next       = ST_DONE;
                    end
                end
            end

            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = res_status_reg;
                    removed_count_next = rem_ext[OUT_CNT_W-1:0];
                    occupancy_next     = occ_ext[OUT_CNT_W-1:0];
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
        end
    end

    // payload and pointer registers
    always_ff @(posedge clk)
    begin
        value_reg         <= value_next;
        scan_idx_reg      <= scan_idx_next;
        pend_idx_reg      <= pend_idx_next;
        wr_ptr_reg        <= wr_ptr_next;
        res_status_reg    <= res_status_next;
        res_removed_reg   <= res_removed_next;
        status_reg        <= status_next;
        removed_count_reg <= removed_count_next;
        occupancy_reg     <= occupancy_next;
    end

    // occupancy never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    // compaction never writes ahead of the entry it just read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REM_SCAN && pend_reg) |-> (wr_ptr_reg <= CW'(pend_idx_reg)))
        else $error("compaction write pointer ran past read pointer");

    // a finished result waits while the output register is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && out_stall) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

    // shifting writes stay inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_SCAN && pend_reg) |-> (CW'(pend_idx_reg) < last_cnt + 1'b1))
        else $error("insert shift beyond occupancy");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import sli_pkg::*;

    localparam int CAPACITY = 16;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // one input transaction and the idle cycles ahead of it
    typedef struct {
        logic                        kind;
        logic signed [VALUE_W-1:0]   value;
        int                          gap;
        bit                          drain;
    } op_txn_t;

    // one result transaction
    typedef struct {
        logic                    status;
        logic [OUT_CNT_W-1:0]    removed_count;
        logic [OUT_CNT_W-1:0]    occupancy;
    } sli_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        op = OP_INSERT;
    logic signed [VALUE_W-1:0]   value = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        status;
    logic [OUT_CNT_W-1:0]        removed_count;
    logic [OUT_CNT_W-1:0]        occupancy;

    op_txn_t                     op_queue[$];
    sli_result_t                 results_due[$];
    logic signed [VALUE_W-1:0]   sorted_vals[$];
    bit                          burst = 1'b0;
    int                          n_ops = 0;
    int                          ops_taken = 0;
    int                          results_seen = 0;
    int                          wait_cycles = 0;
    int                          stall_left = 0;
    int                          errors = 0;
    op_txn_t                     nxt;
    sli_result_t                 want;

    sorted_list_insert_remove #(.CAPACITY(CAPACITY)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_count (removed_count),
        .occupancy     (occupancy)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // apply one operation to the sorted table and return its result
    function automatic sli_result_t table_update(input logic kind,
                                                 input logic signed [VALUE_W-1:0] v);
        sli_result_t r;
        logic signed [VALUE_W-1:0] kept[$];
        int pos;
        int gone;
        r.status = STATUS_DONE;
        gone = 0;
        if (kind == OP_INSERT)
        begin
            if (sorted_vals.size() >= CAPACITY)
                r.status = STATUS_FULL;
            else
            begin
                // new entry lands after every equal one
                pos = 0;
                while (pos < sorted_vals.size() && !(sorted_vals[pos] > v))
                    pos++;
                sorted_vals.push_back(v);
                for (int i = sorted_vals.size() - 1; i > pos; i--)
                    sorted_vals[i] = sorted_vals[i - 1];
                sorted_vals[pos] = v;
            end
        end
        else
        begin
            // drop every match, keep the order of the rest
            foreach (sorted_vals[i])
            begin
                if (sorted_vals[i] != v)
                    kept.push_back(sorted_vals[i]);
                else
                    gone++;
            end
            sorted_vals = kept;
        end
        r.removed_count = OUT_CNT_W'(gone);
        r.occupancy = OUT_CNT_W'(sorted_vals.size());
        return r;
    endfunction

    task automatic add_op(input logic kind, input logic signed [VALUE_W-1:0] v,
                          input bit drain);
        op_txn_t t;
        t.kind = kind;
        t.value = v;
        t.gap = burst ? 0 : $urandom_range(0, 18);
        t.drain = drain;
        op_queue.push_back(t);
    endtask

    // driver: presents queued transactions, holds them while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= OP_INSERT;
            value <= '0;
            wait_cycles = 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (op_queue.size() == 0)
                in_valid <= 1'b0;
            else if (wait_cycles < op_queue[0].gap ||
                     (op_queue[0].drain && (in_valid || results_due.size() != 0)))
            begin
                in_valid <= 1'b0;
                wait_cycles++;
            end
            else
            begin
                nxt = op_queue.pop_front();
                in_valid <= 1'b1;
                op <= nxt.kind;
                value <= nxt.value;
                wait_cycles = 0;
            end
        end
    end

    // monitor: predicts accepted transactions, checks results, drives out_stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                results_due.push_back(table_update(op, value));
                ops_taken++;
            end
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with nothing outstanding: status %0d removed %0d occ %0d",
                           status, removed_count, occupancy);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (removed_count !== want.removed_count)
                    begin
                        $error("removed_count: expected %0d, got %0d",
                               want.removed_count, removed_count);
                        errors++;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                        errors++;
                    end
                end
                results_seen++;
                // some stretches run with no backpressure at all
                stall_left = ((results_seen / 150) % 4 == 3) ? 0 : $urandom_range(0, 18);
            end
            else if (out_valid && out_stall && stall_left > 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // stimulus and end of run
    initial
    begin
        logic signed [VALUE_W-1:0] pool[$];
        logic signed [VALUE_W-1:0] leftover[$];
        logic signed [VALUE_W-1:0] v;
        int seq_idx;
        int len;
        int ins_pct;
        int npool;
        bit flood;

        // directed: empty table, extremes, equal entries, full table
        add_op(OP_REMOVE, 0, 1'b0);
        add_op(OP_INSERT, 0, 1'b0);
        add_op(OP_INSERT, VAL_MAX, 1'b0);
        add_op(OP_INSERT, VAL_MIN, 1'b0);
        add_op(OP_INSERT, -1, 1'b0);
        add_op(OP_INSERT, 1, 1'b0);
        add_op(OP_INSERT, VAL_MAX, 1'b0);
        add_op(OP_INSERT, -1, 1'b0);
        add_op(OP_REMOVE, 1, 1'b0);
        add_op(OP_REMOVE, 42, 1'b0);
        repeat (10)
            add_op(OP_INSERT, 5, 1'b0);
        add_op(OP_INSERT, 5, 1'b0);
        add_op(OP_REMOVE, 5, 1'b0);
        add_op(OP_REMOVE, VAL_MIN, 1'b0);
        add_op(OP_REMOVE, VAL_MAX, 1'b0);
        add_op(OP_REMOVE, -1, 1'b0);
        add_op(OP_REMOVE, 0, 1'b0);

        // random: sequences that load the table from a small pool, then usually clear it
        seq_idx = 0;
        while (op_queue.size() < 1050)
        begin
            burst = (seq_idx % 5 == 4);
            flood = ($urandom_range(0, 7) == 0);
            npool = flood ? 1 : $urandom_range(1, 5);
            pool.delete();
            repeat (npool)
            begin
                case ($urandom_range(0, 7))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = 0;
                    3: v = -1;
                    default: v = $urandom;
                endcase
                pool.push_back(v);
            end

            // clear values left by an earlier broken sequence
            if (leftover.size() != 0 && $urandom_range(0, 1) == 0)
            begin
                foreach (leftover[i])
                    add_op(OP_REMOVE, leftover[i], 1'b0);
                leftover.delete();
            end

            len = flood ? $urandom_range(16, 18) : $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: ins_pct = 90;
                1: ins_pct = 70;
                default: ins_pct = 50;
            endcase
            if (flood)
                ins_pct = 100;
            for (int k = 0; k < len; k++)
            begin
                if (!flood && $urandom_range(0, 19) == 0)
                    add_op(OP_REMOVE, $urandom, 1'b0);
                else
                    add_op(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE,
                           pool[$urandom_range(0, npool - 1)],
                           (k == 0 && seq_idx % 12 == 0));
            end

            // usually remove every pool value, sometimes leave them behind
            if ($urandom_range(0, 9) == 0)
            begin
                foreach (pool[i])
                    leftover.push_back(pool[i]);
            end
            else
            begin
                foreach (pool[i])
                    add_op(OP_REMOVE, pool[i], 1'b0);
            end
            seq_idx++;
        end
        n_ops = op_queue.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_taken != n_ops || results_due.size() != 0)
            @(posedge clk);
        repeat (3 * CAPACITY) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #(20_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
